// ===== design/var_pkg.sv =====
// ----------------------------------------------------------------------------
// var_pkg
// Shared types, widths and constants of the vector axis rotation unit.
// ----------------------------------------------------------------------------
package var_pkg;

   localparam int DATA_WIDTH    = 16;
   localparam int ANGLE_WIDTH   = 16;
   localparam int AXIS_WIDTH    = 2;
   localparam int CORDIC_STAGES = 16;
   localparam int GUARD_BITS    = 16;
   localparam int TABLE_LEN     = 32;
   localparam int IDX_WIDTH     = 5;
   localparam int GAIN_WIDTH    = 32;
   localparam int ACC_WIDTH     = DATA_WIDTH + GUARD_BITS + 4;
   localparam int TURN_WIDTH    = 33;
   localparam int NUM_CELLS     = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

   localparam logic signed [GAIN_WIDTH-1:0] GAIN_Q31 = 32'sd1304065748;

   localparam logic [AXIS_WIDTH-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_WIDTH-1:0] AXIS_Y = 2'd1;
   localparam logic [AXIS_WIDTH-1:0] AXIS_Z = 2'd2;

   localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0]  comp_x;
      logic signed [DATA_WIDTH-1:0]  comp_y;
      logic signed [DATA_WIDTH-1:0]  comp_z;
      logic        [ANGLE_WIDTH-1:0] turn_angle;
      logic        [AXIS_WIDTH-1:0]  axis_index;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] out_x;
      logic signed [DATA_WIDTH-1:0] out_y;
      logic signed [DATA_WIDTH-1:0] out_z;
      logic                         saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [ACC_WIDTH-1:0]  x;
      logic signed [ACC_WIDTH-1:0]  y;
      logic signed [TURN_WIDTH-1:0] t;
      logic        [AXIS_WIDTH-1:0] axis;
      logic signed [DATA_WIDTH-1:0] pass;
   } stage_type;

endpackage

// ===== design/vector_axis_rotation_unit.sv =====
// ----------------------------------------------------------------------------
// vector_axis_rotation_unit
// Rotates a three-component Q1.14 vector about one axis through a chain of
// pipelined CORDIC cells.
// ----------------------------------------------------------------------------
//   channel   direction   handshake              word
//   req       in          req_valid/req_ready    req_type
//   rsp       out         rsp_valid/rsp_ready    rsp_type
//
// One word per cycle sustained while the output skid is not full; the path
// holds two prep stages, one stage per CORDIC cell and the output register.
// The whole chain advances together; it holds only while the output skid's
// spare entry is occupied, so one word is still taken after the output stalls.
// Synchronous reset clears valid bits only.
// ----------------------------------------------------------------------------
module vector_axis_rotation_unit
   import var_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   logic      pipe_enable;
   logic      chain_valid [NUM_CELLS+1];
   stage_type chain_stage [NUM_CELLS+1];

   assign req_ready = pipe_enable;

   var_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .enable    (pipe_enable),
      .in_valid  (req_valid),
      .in_word   (req_word),
      .out_valid (chain_valid[0]),
      .out_stage (chain_stage[0])
   );

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      var_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (pipe_enable),
         .stage_idx (IDX_WIDTH'(k)),
         .in_valid  (chain_valid[k]),
         .in_stage  (chain_stage[k]),
         .out_valid (chain_valid[k+1]),
         .out_stage (chain_stage[k+1])
      );
   end

   var_out u_out (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (chain_valid[NUM_CELLS]),
      .in_stage    (chain_stage[NUM_CELLS]),
      .pipe_enable (pipe_enable),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word)
   );

endmodule

// ===== design/var_prep.sv =====
// ----------------------------------------------------------------------------
// var_prep
// Axis selection, quadrant fold and gain compensation, two register stages.
// ----------------------------------------------------------------------------
module var_prep
   import var_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      enable,
   input  logic      in_valid,
   input  req_type   in_word,
   output logic      out_valid,
   output stage_type out_stage
);

   localparam int EXT_WIDTH  = DATA_WIDTH + 1;
   localparam int PROD_WIDTH = EXT_WIDTH + GAIN_WIDTH;
   localparam logic signed [TURN_WIDTH-1:0] QUARTER = TURN_WIDTH'(64'sd1073741824);
   localparam logic signed [TURN_WIDTH-1:0] HALF    = TURN_WIDTH'(64'sd2147483648);

   logic                          fold_valid_ff;
   logic signed [EXT_WIDTH-1:0]   a_ff, a_in;
   logic signed [EXT_WIDTH-1:0]   b_ff, b_in;
   logic signed [TURN_WIDTH-1:0]  t_ff, t_in;
   logic        [AXIS_WIDTH-1:0]  axis_ff, axis_in;
   logic signed [DATA_WIDTH-1:0]  pass_ff, pass_in;
   logic                          valid_ff;
   stage_type                     stage_ff, stage_in;

   logic signed [EXT_WIDTH-1:0]   a_sel, b_sel;
   logic signed [TURN_WIDTH-1:0]  t_raw;
   logic signed [PROD_WIDTH-1:0]  prod_a, prod_b;

   always_comb begin
      axis_in = (in_word.axis_index > AXIS_Z) ? AXIS_Z : in_word.axis_index;
      case (axis_in)
         AXIS_X: begin
            a_sel   = EXT_WIDTH'(in_word.comp_y);
            b_sel   = EXT_WIDTH'(in_word.comp_z);
            pass_in = in_word.comp_x;
         end
         AXIS_Y: begin
            a_sel   = EXT_WIDTH'(in_word.comp_z);
            b_sel   = EXT_WIDTH'(in_word.comp_x);
            pass_in = in_word.comp_y;
         end
         default: begin
            a_sel   = EXT_WIDTH'(in_word.comp_x);
            b_sel   = EXT_WIDTH'(in_word.comp_y);
            pass_in = in_word.comp_z;
         end
      endcase
      t_raw = TURN_WIDTH'(signed'({in_word.turn_angle, 16'b0}));
      if (t_raw > QUARTER) begin
         a_in = -a_sel;
         b_in = -b_sel;
         t_in = t_raw - HALF;
      end else if (t_raw < -QUARTER) begin
         a_in = -a_sel;
         b_in = -b_sel;
         t_in = t_raw + HALF;
      end else begin
         a_in = a_sel;
         b_in = b_sel;
         t_in = t_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
      end else if (enable) begin
         fold_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         t_ff    <= t_in;
         axis_ff <= axis_in;
         pass_ff <= pass_in;
      end
   end

   always_comb begin
      prod_a        = PROD_WIDTH'(a_ff) * PROD_WIDTH'(GAIN_Q31);
      prod_b        = PROD_WIDTH'(b_ff) * PROD_WIDTH'(GAIN_Q31);
      stage_in.x    = ACC_WIDTH'(prod_a >>> (31 - GUARD_BITS));
      stage_in.y    = ACC_WIDTH'(prod_b >>> (31 - GUARD_BITS));
      stage_in.t    = t_ff;
      stage_in.axis = axis_ff;
      stage_in.pass = pass_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= fold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// ===== design/var_cell.sv =====
// ----------------------------------------------------------------------------
// var_cell
// One CORDIC micro-rotation with its register stage.
// ----------------------------------------------------------------------------
module var_cell
   import var_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic [IDX_WIDTH-1:0] stage_idx,
   input  logic                 in_valid,
   input  stage_type            in_stage,
   output logic                 out_valid,
   output stage_type            out_stage
);

   logic                         valid_ff;
   stage_type                    stage_ff, stage_in;
   logic signed [ACC_WIDTH-1:0]  x_sh, y_sh;
   logic signed [TURN_WIDTH-1:0] step;

   always_comb begin
      x_sh     = in_stage.x >>> stage_idx;
      y_sh     = in_stage.y >>> stage_idx;
      step     = signed'(TURN_WIDTH'(ATAN_TABLE[stage_idx]));
      stage_in = in_stage;
      if (!in_stage.t[TURN_WIDTH-1]) begin
         stage_in.x = in_stage.x - y_sh;
         stage_in.y = in_stage.y + x_sh;
         stage_in.t = in_stage.t - step;
      end else begin
         stage_in.x = in_stage.x + y_sh;
         stage_in.y = in_stage.y - x_sh;
         stage_in.t = in_stage.t + step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// ===== design/var_out.sv =====
// ----------------------------------------------------------------------------
// var_out
// Rounding, saturation and reassembly, into a two-entry output skid buffer.
// ----------------------------------------------------------------------------
module var_out
   import var_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  stage_type in_stage,
   output logic      pipe_enable,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_word
);

   localparam int RND_WIDTH = ACC_WIDTH + 1;
   localparam logic signed [RND_WIDTH-1:0] HALF_LSB = RND_WIDTH'(1) <<< (GUARD_BITS - 1);
   localparam logic signed [RND_WIDTH-1:0] HI = RND_WIDTH'((64'sd1 <<< (DATA_WIDTH - 1)) - 1);
   localparam logic signed [RND_WIDTH-1:0] LO = -HI - RND_WIDTH'(1);

   logic                         main_valid_ff, main_valid_in;
   logic                         spare_valid_ff, spare_valid_in;
   rsp_type                      main_ff, main_in;
   rsp_type                      spare_ff, spare_in;
   rsp_type                      result;
   logic signed [RND_WIDTH-1:0]  ra, rb;
   logic signed [DATA_WIDTH-1:0] qa, qb;
   logic                         clip_a, clip_b;
   logic                         push, pop;

   always_comb begin
      ra = (RND_WIDTH'(in_stage.x) + HALF_LSB) >>> GUARD_BITS;
      rb = (RND_WIDTH'(in_stage.y) + HALF_LSB) >>> GUARD_BITS;
      clip_a = (ra > HI) || (ra < LO);
      clip_b = (rb > HI) || (rb < LO);
      qa = (ra > HI) ? DATA_WIDTH'(HI) : ((ra < LO) ? DATA_WIDTH'(LO) : DATA_WIDTH'(ra));
      qb = (rb > HI) ? DATA_WIDTH'(HI) : ((rb < LO) ? DATA_WIDTH'(LO) : DATA_WIDTH'(rb));
      result.saturated = clip_a | clip_b;
      case (in_stage.axis)
         AXIS_X: begin
            result.out_x = in_stage.pass;
            result.out_y = qa;
            result.out_z = qb;
         end
         AXIS_Y: begin
            result.out_x = qb;
            result.out_y = in_stage.pass;
            result.out_z = qa;
         end
         default: begin
            result.out_x = qa;
            result.out_y = qb;
            result.out_z = in_stage.pass;
         end
      endcase
   end

   assign pipe_enable = !spare_valid_ff;
   assign push        = pipe_enable && in_valid;
   assign pop         = main_valid_ff && rsp_ready;

   always_comb begin
      main_valid_in  = main_valid_ff;
      spare_valid_in = spare_valid_ff;
      main_in        = main_ff;
      spare_in       = spare_ff;
      if (pop) begin
         if (spare_valid_ff) begin
            main_in        = spare_ff;
            spare_valid_in = 1'b0;
         end else begin
            main_in       = result;
            main_valid_in = push;
         end
      end else if (!main_valid_ff) begin
         main_in       = result;
         main_valid_in = push;
      end else if (push) begin
         spare_in       = result;
         spare_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff  <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         main_valid_ff  <= main_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff  <= main_in;
      spare_ff <= spare_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_word  = main_ff;

endmodule

// ===== design/var_checker.sv =====
// ----------------------------------------------------------------------------
// var_checker
// Port-level checks on the vector axis rotation unit, bound to the top level.
// ----------------------------------------------------------------------------
module var_checker
   import var_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_word
);

   localparam logic signed [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("stalled response word changed");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no word waiting at output");

   a_sat_at_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.saturated |->
         rsp_word.out_x == MAX_VAL || rsp_word.out_x == MIN_VAL ||
         rsp_word.out_y == MAX_VAL || rsp_word.out_y == MIN_VAL ||
         rsp_word.out_z == MAX_VAL || rsp_word.out_z == MIN_VAL)
      else $error("saturated flag without a clipped component");

endmodule

bind vector_axis_rotation_unit var_checker u_checker (.*);

// ===== tb/vector_axis_rotation_unit_tb.sv =====
// ----------------------------------------------------------------------------
// vector_axis_rotation_unit_tb
// Streams vectors through the rotation unit with random gaps on both sides
// and checks every response word against a bit-true CORDIC predictor.
// Directed words cover range extremes, every axis (index three included),
// quadrant-fold boundaries of the angle and saturating rotations.
// ----------------------------------------------------------------------------
module vector_axis_rotation_unit_tb;
   import var_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int     ROT_STAGES  = 16;
   localparam int     FRAC_GUARD  = 16;
   localparam longint ROT_GAIN    = 64'sd1304065748;
   localparam longint HALF_REV    = 64'sd2147483648;
   localparam longint QUARTER_REV = 64'sd1073741824;
   localparam longint COMP_MAX    = 64'sd32767;
   localparam longint COMP_MIN    = -64'sd32768;
   localparam int     RANDOM_WORDS = 600;
   localparam int     DRAIN_CYCLES = 40;

   localparam longint ATAN_TURNS [32] = '{
      536870912, 316933406, 167458907, 85004756,
      42667331,  21354465,  10679838,  5340245,
      2670163,   1335087,   667544,    333772,
      166886,    83443,     41722,     20861,
      10430,     5215,      2608,      1304,
      652,       326,       163,       81,
      41,        20,        10,        5,
      3,         1,         1,         0
   };

   class rotation_scoreboard;
      rsp_type pending[$];
      int      errors;

      function new();
         errors = 0;
      endfunction

      function longint round_clip(longint v, ref bit clip);
         longint r;
         r = (v + (64'sd1 <<< (FRAC_GUARD - 1))) >>> FRAC_GUARD;
         if (r > COMP_MAX) begin
            clip = 1'b1;
            return COMP_MAX;
         end
         if (r < COMP_MIN) begin
            clip = 1'b1;
            return COMP_MIN;
         end
         return r;
      endfunction

      function rsp_type predict_word(req_type w);
         longint  comp [3];
         longint  a, b, x, y, nx, ny, t;
         int      axis, ia, ib;
         bit      clip;
         rsp_type r;
         axis = int'((w.axis_index > AXIS_Z) ? AXIS_Z : w.axis_index);
         comp[0] = longint'(signed'(w.comp_x));
         comp[1] = longint'(signed'(w.comp_y));
         comp[2] = longint'(signed'(w.comp_z));
         ia = (axis + 1) % 3;
         ib = (axis + 2) % 3;
         a = comp[ia];
         b = comp[ib];
         t = longint'(signed'({w.turn_angle, 16'h0000}));
         if (t > QUARTER_REV) begin
            a = -a;
            b = -b;
            t = t - HALF_REV;
         end else if (t < -QUARTER_REV) begin
            a = -a;
            b = -b;
            t = t + HALF_REV;
         end
         x = (a * ROT_GAIN) >>> (31 - FRAC_GUARD);
         y = (b * ROT_GAIN) >>> (31 - FRAC_GUARD);
         for (int i = 0; i < ROT_STAGES; i++) begin
            if (t >= 0) begin
               nx = x - (y >>> i);
               ny = y + (x >>> i);
               t  = t - ATAN_TURNS[i];
            end else begin
               nx = x + (y >>> i);
               ny = y - (x >>> i);
               t  = t + ATAN_TURNS[i];
            end
            x = nx;
            y = ny;
         end
         clip = 1'b0;
         comp[ia] = round_clip(x, clip);
         comp[ib] = round_clip(y, clip);
         r.out_x     = comp[0][15:0];
         r.out_y     = comp[1][15:0];
         r.out_z     = comp[2][15:0];
         r.saturated = clip;
         return r;
      endfunction

      function void note_request(req_type w);
         pending.push_back(predict_word(w));
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $error("response word with nothing outstanding");
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.out_x !== want.out_x) begin
            $error("out_x: expected %0d, actual %0d", want.out_x, got.out_x);
            errors++;
         end
         if (got.out_y !== want.out_y) begin
            $error("out_y: expected %0d, actual %0d", want.out_y, got.out_y);
            errors++;
         end
         if (got.out_z !== want.out_z) begin
            $error("out_z: expected %0d, actual %0d", want.out_z, got.out_z);
            errors++;
         end
         if (got.saturated !== want.saturated) begin
            $error("saturated: expected %0d, actual %0d", want.saturated, got.saturated);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_word;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_word;
   bit      steady;

   rotation_scoreboard sb = new();

   vector_axis_rotation_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.note_request(req_word);
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_word);
   end

   // response side: random stall before each word
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   function automatic req_type make_word(logic [15:0] cx, logic [15:0] cy,
                                         logic [15:0] cz, logic [15:0] ang,
                                         logic [1:0] ax);
      req_type w;
      w.comp_x     = cx;
      w.comp_y     = cy;
      w.comp_z     = cz;
      w.turn_angle = ang;
      w.axis_index = ax;
      return w;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_word(req_type w);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   function automatic logic [15:0] random_comp();
      if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, 65535));
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   initial begin
      req_type w;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      steady    = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // extremes, every axis, quadrant folds and saturation
      send_word(make_word(16'h0000, 16'h0000, 16'h0000, 16'h0000, AXIS_X));
      send_word(make_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, AXIS_X));
      send_word(make_word(16'h8000, 16'h8000, 16'h8000, 16'h0000, AXIS_Y));
      send_word(make_word(16'h4000, 16'h0000, 16'h0000, 16'h4000, AXIS_Z));
      send_word(make_word(16'h4000, 16'h0000, 16'h0000, 16'h4001, AXIS_Z));
      send_word(make_word(16'h4000, 16'h2000, 16'h1000, 16'h8000, AXIS_Z));
      send_word(make_word(16'h4000, 16'h2000, 16'h1000, 16'hBFFF, AXIS_Z));
      send_word(make_word(16'h4000, 16'h2000, 16'h1000, 16'hC000, AXIS_Z));
      send_word(make_word(16'h4000, 16'h2000, 16'h1000, 16'hFFFF, AXIS_X));
      send_word(make_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h2000, AXIS_X));
      send_word(make_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h2000, AXIS_Y));
      send_word(make_word(16'h8000, 16'h8000, 16'h8000, 16'hE000, AXIS_Z));
      send_word(make_word(16'h8000, 16'h7FFF, 16'h8000, 16'h6000, 2'd3));
      send_word(make_word(16'h1234, 16'hEDCB, 16'h7FFF, 16'h1555, 2'd3));
      send_word(make_word(16'h8000, 16'h0000, 16'h0000, 16'h8000, AXIS_Y));
      send_word(make_word(16'h0000, 16'h8000, 16'h0000, 16'h8000, AXIS_X));
      send_word(make_word(16'h7FFF, 16'h8000, 16'h7FFF, 16'h4000, AXIS_Y));
      send_word(make_word(16'h7FFF, 16'h8000, 16'h7FFF, 16'hC000, AXIS_Z));
      send_word(make_word(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, AXIS_X));
      send_word(make_word(16'h5A82, 16'h5A82, 16'h8000, 16'hA000, AXIS_Z));

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 64 == 0) steady = ($urandom_range(0, 3) == 0);
         w.comp_x     = random_comp();
         w.comp_y     = random_comp();
         w.comp_z     = random_comp();
         w.turn_angle = 16'($urandom_range(0, 65535));
         w.axis_index = 2'($urandom_range(0, 3));
         send_word(w);
      end
      req_valid <= 1'b0;
      steady = 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
